FILE: sv/motor_duty_exponential_ramp_unit_macros.svh
// ----------------------------------------------------------------------------
// Motor duty ramp assertion macros
// Shared assertion forms for the motor duty ramp unit.
// ----------------------------------------------------------------------------
`ifndef MOTOR_DUTY_EXPONENTIAL_RAMP_UNIT_MACROS_SVH
`define MOTOR_DUTY_EXPONENTIAL_RAMP_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MDER_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MDER_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mder_pkg.sv
// ----------------------------------------------------------------------------
// Motor duty ramp package
// Types, constants and the correction function of the motor duty ramp unit.
// ----------------------------------------------------------------------------
package mder_pkg;

    localparam int unsigned SpeedW = 16;
    localparam int unsigned DirW   = 8;
    localparam int unsigned DutyW  = 10;

    localparam logic [SpeedW-1:0] BAND_HIGH = 16'd3000;
    localparam logic [SpeedW-1:0] BAND_MID  = 16'd2000;
    localparam logic [SpeedW-1:0] STEP_HIGH = 16'd200;
    localparam logic [SpeedW-1:0] STEP_MID  = 16'd150;
    localparam logic [SpeedW-1:0] STEP_LOW  = 16'd100;

    localparam logic [DutyW-1:0] DUTY_MAX       = 10'd1023;
    localparam logic [DutyW-1:0] DUTY_TOP_LIMIT = 10'd1022;
    localparam logic [DutyW-1:0] DUTY_KICK      = 10'd1000;

    localparam logic [DirW-1:0] DIR_FORWARD = 8'd1;
    localparam logic [DirW-1:0] DIR_REVERSE = 8'd0;

    // Quotients of ten or more saturate the correction.
    localparam int unsigned QuotSat = 10;

    typedef struct packed {
        logic [DutyW-1:0] duty;
        logic             reverse;
    } mder_state_t;

    // Correction 2^q - 1 with q = err / step. The quotient is only needed up
    // to saturation, so it is found by comparing against multiples of the step.
    function automatic logic [DutyW-1:0] correction_of(input logic [SpeedW-1:0] err);
        logic [SpeedW-1:0] step;
        logic [3:0]        quot;
        logic [31:0]       err_w;
        logic [DutyW:0]    pow;
        step  = STEP_LOW;
        quot  = 4'd0;
        err_w = {16'd0, err};
        if (err > BAND_HIGH) begin
            step = STEP_HIGH;
        end else if (err > BAND_MID) begin
            step = STEP_MID;
        end
        for (int k = 1; k < QuotSat; k++) begin
            if (err_w >= 32'(k) * {16'd0, step}) begin
                quot = 4'(k);
            end
        end
        pow = (11'd1 << quot) - 11'd1;
        if (err_w >= 32'(QuotSat) * {16'd0, step}) begin
            return DUTY_MAX;
        end
        return pow[DutyW-1:0];
    endfunction

endpackage

FILE: sv/motor_duty_exponential_ramp_unit.sv
// ----------------------------------------------------------------------------
// Motor duty exponential ramp unit
// Takes one item per clock cycle while the receiver keeps taking results, and
// produces one result item for each. An item is captured in an input register;
// once the result register is free or being taken, the update logic computes
// its duty and direction from the held state and writes them to the result
// register together with the new held state. The held duty and direction live in
// one register pair that the update logic rewrites as each item moves on, which
// is what sets the sustained rate of one item per cycle. The input side
// accepts while its register is empty, or while the item in it moves on
// because the result register is free or being taken in the same cycle.
// ----------------------------------------------------------------------------
`include "motor_duty_exponential_ramp_unit_macros.svh"

module motor_duty_exponential_ramp_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [mder_pkg::SpeedW-1:0] s_request_speed,
    input  logic [mder_pkg::DirW-1:0]   s_direction_request,
    input  logic [mder_pkg::SpeedW-1:0] s_wheel_a_speed,
    input  logic [mder_pkg::SpeedW-1:0] s_wheel_b_speed,
    input  logic                        s_measurement_new,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mder_pkg::DutyW-1:0]  m_duty,
    output logic                        m_reverse
);

    logic                        in_valid_reg;
    logic [mder_pkg::SpeedW-1:0] req_reg;
    logic [mder_pkg::DirW-1:0]   dir_reg;
    logic [mder_pkg::SpeedW-1:0] left_reg;
    logic [mder_pkg::SpeedW-1:0] right_reg;
    logic                        fresh_reg;

    mder_pkg::mder_state_t       held_reg;
    mder_pkg::mder_state_t       held_next;

    logic                        out_valid_reg;
    logic [mder_pkg::DutyW-1:0]  duty_reg;
    logic [mder_pkg::DutyW-1:0]  duty_next;
    logic                        reverse_reg;
    logic                        reverse_next;

    logic                        advance;
    logic                        take_in;

    // The item in the input register moves on when the result register is
    // empty or its item is being taken.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take_in = s_valid && s_ready;

    mder_update u_update (
        .request_speed     (req_reg),
        .direction_request (dir_reg),
        .wheel_a_speed     (left_reg),
        .wheel_b_speed     (right_reg),
        .measurement_new   (fresh_reg),
        .held              (held_reg),
        .held_next         (held_next),
        .duty              (duty_next),
        .reverse           (reverse_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end else begin
            if (take_in) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                held_reg      <= held_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            req_reg   <= s_request_speed;
            dir_reg   <= s_direction_request;
            left_reg  <= s_wheel_a_speed;
            right_reg <= s_wheel_b_speed;
            fresh_reg <= s_measurement_new;
        end
        if (advance) begin
            duty_reg    <= duty_next;
            reverse_reg <= reverse_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_duty    = duty_reg;
    assign m_reverse = reverse_reg;

    `MDER_ASSERT_NEXT(a_stop_gives_zero, aclk, aresetn, advance && (req_reg <= 16'd1), m_duty == '0, "stop request did not give zero duty")
    `MDER_ASSERT_NEXT(a_stale_keeps_state, aclk, aresetn, advance && !fresh_reg, $stable(held_reg), "held state changed without a fresh measurement")
    `MDER_ASSERT_SAME(a_result_tracks_state, aclk, aresetn, out_valid_reg, (m_reverse == held_reg.reverse) && (m_duty == '0 || m_duty == held_reg.duty), "result differs from held state")
    `MDER_ASSERT_NEXT(a_advance_fills_output, aclk, aresetn, advance, out_valid_reg, "result register not filled after update")

endmodule

FILE: sv/mder_update.sv
// ----------------------------------------------------------------------------
// Motor duty ramp update
// Combinational ramp step: next held state and result from one item.
// ----------------------------------------------------------------------------
module mder_update (
    input  logic [mder_pkg::SpeedW-1:0] request_speed,
    input  logic [mder_pkg::DirW-1:0]   direction_request,
    input  logic [mder_pkg::SpeedW-1:0] wheel_a_speed,
    input  logic [mder_pkg::SpeedW-1:0] wheel_b_speed,
    input  logic                        measurement_new,
    input  mder_pkg::mder_state_t       held,
    output mder_pkg::mder_state_t       held_next,
    output logic [mder_pkg::DutyW-1:0]  duty,
    output logic                        reverse
);

    logic [mder_pkg::SpeedW:0]   speed_sum;
    logic [mder_pkg::SpeedW-1:0] mean;
    logic [mder_pkg::SpeedW-1:0] err;
    logic                        too_fast;
    logic [mder_pkg::DutyW-1:0]  corr;
    logic [mder_pkg::DutyW-1:0]  base;
    logic [mder_pkg::DutyW:0]    raised;
    logic                        stop;
    logic                        rev_new;

    assign speed_sum = {1'b0, wheel_a_speed} + {1'b0, wheel_b_speed};
    assign mean      = speed_sum[mder_pkg::SpeedW:1];
    assign too_fast  = mean > request_speed;
    assign err       = too_fast ? (mean - request_speed) : (request_speed - mean);
    assign corr      = mder_pkg::correction_of(err);
    // A stalled wheel pair kicks the duty to a fixed value before correcting.
    assign base      = (mean == '0) ? mder_pkg::DUTY_KICK : held.duty;
    assign raised    = {1'b0, base} + {1'b0, corr};
    assign stop      = request_speed <= 16'd1;

    always_comb begin
        rev_new = held.reverse;
        if (direction_request == mder_pkg::DIR_FORWARD) begin
            rev_new = 1'b0;
        end else if (direction_request == mder_pkg::DIR_REVERSE) begin
            rev_new = 1'b1;
        end
    end

    always_comb begin
        held_next = held;
        if (!stop && measurement_new) begin
            held_next.reverse = rev_new;
            if (too_fast) begin
                held_next.duty = (corr > base) ? '0 : (base - corr);
            end else if (raised > {1'b0, mder_pkg::DUTY_TOP_LIMIT}) begin
                held_next.duty = mder_pkg::DUTY_MAX;
            end else begin
                held_next.duty = raised[mder_pkg::DutyW-1:0];
            end
        end
        duty    = stop ? '0 : held_next.duty;
        reverse = held_next.reverse;
    end

endmodule

FILE: sim/motor_duty_exponential_ramp_unit_tb.sv
// ----------------------------------------------------------------------------
// Motor duty exponential ramp unit testbench
// Drives ramp update items through the valid/ready input channel and checks
// every result item against a cycle-free predictor of the held duty and
// direction. A directed table covers the stop request, held output, the zero
// speed kick, the speed extremes, the unwrapped sum and the error bands; a
// shaped random part follows, with random idling on both sides, a calm
// stretch and one long stall of the receiver.
// ----------------------------------------------------------------------------
module motor_duty_exponential_ramp_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRows     = 21;
    localparam int RandomItems = 1430;
    localparam int TotalItems  = NumRows + RandomItems;
    // Longest quiet spell in a correct run is the receiver hold-off.
    localparam int QuietLimit  = 2000;
    localparam int HoldOff     = 80;

    typedef struct packed {
        logic [mder_pkg::SpeedW-1:0] req;
        logic [mder_pkg::DirW-1:0]   dir;
        logic [mder_pkg::SpeedW-1:0] left;
        logic [mder_pkg::SpeedW-1:0] right;
        logic                        fresh;
    } ramp_item_t;

    typedef struct packed {
        logic [mder_pkg::DutyW-1:0] duty;
        logic                       reverse;
    } duty_result_t;

    typedef struct packed {
        ramp_item_t   item;
        logic         typed;
        duty_result_t res;
    } ramp_row_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [mder_pkg::SpeedW-1:0] s_request_speed;
    logic [mder_pkg::DirW-1:0]   s_direction_request;
    logic [mder_pkg::SpeedW-1:0] s_wheel_a_speed;
    logic [mder_pkg::SpeedW-1:0] s_wheel_b_speed;
    logic                        s_measurement_new;
    logic                        m_valid;
    logic                        m_ready;
    logic [mder_pkg::DutyW-1:0]  m_duty;
    logic                        m_reverse;

    ramp_row_t                   ramp_rows [NumRows];
    duty_result_t                due_duty_q [$];
    logic [mder_pkg::DutyW-1:0]  held_duty_model;
    logic                        held_reverse_model;
    logic                        calm;
    int                          results_seen;
    int                          quiet_cycles;
    int                          fail_count;

    motor_duty_exponential_ramp_unit DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_request_speed     (s_request_speed),
        .s_direction_request (s_direction_request),
        .s_wheel_a_speed     (s_wheel_a_speed),
        .s_wheel_b_speed     (s_wheel_b_speed),
        .s_measurement_new   (s_measurement_new),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_duty              (m_duty),
        .m_reverse           (m_reverse)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Advances the held duty and direction by one item and returns the result.
    function automatic duty_result_t predict_ramp_update(input ramp_item_t it);
        duty_result_t r;
        int unsigned  mean;
        int unsigned  err;
        int unsigned  quot;
        int unsigned  corr;
        int unsigned  held;
        int unsigned  next;
        if (it.req <= 1) begin
            r.duty    = '0;
            r.reverse = held_reverse_model;
            return r;
        end
        if (it.fresh) begin
            if (it.dir == mder_pkg::DIR_FORWARD) begin
                held_reverse_model = 1'b0;
            end else if (it.dir == mder_pkg::DIR_REVERSE) begin
                held_reverse_model = 1'b1;
            end
            mean = (int'(it.left) + int'(it.right)) >> 1;
            if (mean == 0) begin
                held_duty_model = mder_pkg::DUTY_KICK;
            end
            held = held_duty_model;
            err  = (mean > it.req) ? mean - it.req : it.req - mean;
            if (err > mder_pkg::BAND_HIGH) begin
                quot = err / mder_pkg::STEP_HIGH;
            end else if (err > mder_pkg::BAND_MID) begin
                quot = err / mder_pkg::STEP_MID;
            end else begin
                quot = err / mder_pkg::STEP_LOW;
            end
            corr = (quot >= mder_pkg::QuotSat) ? mder_pkg::DUTY_MAX : (1 << quot) - 1;
            if (mean > it.req) begin
                next = (corr > held) ? 0 : held - corr;
            end else begin
                next = held + corr;
                if (next > mder_pkg::DUTY_TOP_LIMIT) begin
                    next = mder_pkg::DUTY_MAX;
                end
            end
            held_duty_model = next[mder_pkg::DutyW-1:0];
        end
        r.duty    = held_duty_model;
        r.reverse = held_reverse_model;
        return r;
    endfunction

    // Mostly well-formed updates whose mean speed sits near the request, so
    // that the unsaturated corrections are reached, plus stops, stale
    // measurements, zero speeds and fully random noise.
    function automatic ramp_item_t random_ramp_item();
        ramp_item_t it;
        int         kind;
        int         off;
        int         mean;
        int         sum;
        int         lo;
        int         hi;
        kind     = $urandom_range(99);
        it.req   = 16'($urandom_range(65535, 2));
        it.left  = 16'($urandom);
        it.right = 16'($urandom);
        it.fresh = 1'b1;
        if ($urandom_range(3) == 0) begin
            it.dir = 8'($urandom);
        end else begin
            it.dir = $urandom_range(1) ? mder_pkg::DIR_FORWARD : mder_pkg::DIR_REVERSE;
        end
        if (kind < 8) begin
            it.req   = 16'($urandom_range(1));
            it.fresh = 1'($urandom);
        end else if (kind < 25) begin
            it.fresh = 1'b0;
        end else if (kind < 35) begin
            it.req   = 16'($urandom);
            it.fresh = 1'($urandom);
        end else if (kind < 40) begin
            it.left  = 16'($urandom_range(1));
            it.right = '0;
        end else begin
            if ($urandom_range(3) == 0) begin
                off = int'($urandom_range(7000)) - 3500;
            end else begin
                off = int'($urandom_range(2200)) - 1100;
            end
            mean = int'(it.req) + off;
            mean = (mean < 0) ? 0 : (mean > 65535) ? 65535 : mean;
            sum  = 2 * mean + int'($urandom_range(1));
            if (sum > 131070) begin
                sum = 131070;
            end
            lo       = (sum > 65535) ? sum - 65535 : 0;
            hi       = (sum < 65535) ? sum : 65535;
            it.left  = 16'($urandom_range(hi, lo));
            it.right = 16'(sum - int'(it.left));
        end
        return it;
    endfunction

    initial begin
        // Stop requests and stale measurements straight after reset.
        ramp_rows[0]  = '{'{16'd0, 8'd0, 16'd65535, 16'd65535, 1'b1}, 1'b1, '{10'd0, 1'b0}};
        ramp_rows[1]  = '{'{16'd1, 8'd255, 16'd0, 16'd0, 1'b1}, 1'b1, '{10'd0, 1'b0}};
        ramp_rows[2]  = '{'{16'd65535, 8'd0, 16'd0, 16'd0, 1'b0}, 1'b1, '{10'd0, 1'b0}};
        // Zero mean speed kicks the duty to 1000, then the speed extremes.
        ramp_rows[3]  = '{'{16'd2, 8'd0, 16'd0, 16'd0, 1'b1}, 1'b1, '{10'd1000, 1'b1}};
        ramp_rows[4]  = '{'{16'd2, 8'd255, 16'd65535, 16'd65535, 1'b1}, 1'b1, '{10'd0, 1'b1}};
        ramp_rows[5]  = '{'{16'd65535, 8'd1, 16'd0, 16'd0, 1'b1}, 1'b1, '{10'd1023, 1'b0}};
        ramp_rows[6]  = '{'{16'd500, 8'd2, 16'd500, 16'd500, 1'b1}, 1'b1, '{10'd1023, 1'b0}};
        ramp_rows[7]  = '{'{16'd2, 8'd255, 16'd65535, 16'd65535, 1'b1}, 1'b1, '{10'd0, 1'b0}};
        // A wheel sum that would wrap to zero in 16 bits must not kick.
        ramp_rows[8]  = '{'{16'd32766, 8'd128, 16'd65535, 16'd1, 1'b1}, 1'b1, '{10'd0, 1'b0}};
        // Error bands and their boundaries.
        ramp_rows[9]  = '{'{16'd1100, 8'd1, 16'd1000, 16'd1000, 1'b1}, 1'b0, '0};
        ramp_rows[10] = '{'{16'd1999, 8'd0, 16'd1000, 16'd1000, 1'b1}, 1'b0, '0};
        ramp_rows[11] = '{'{16'd1000, 8'd7, 16'd1200, 16'd1201, 1'b1}, 1'b0, '0};
        ramp_rows[12] = '{'{16'd1000, 8'd0, 16'd3000, 16'd3000, 1'b1}, 1'b0, '0};
        ramp_rows[13] = '{'{16'd4001, 8'd0, 16'd2000, 16'd2000, 1'b1}, 1'b0, '0};
        ramp_rows[14] = '{'{16'd1000, 8'd0, 16'd4000, 16'd4000, 1'b1}, 1'b0, '0};
        ramp_rows[15] = '{'{16'd5001, 8'd0, 16'd2000, 16'd2000, 1'b1}, 1'b0, '0};
        ramp_rows[16] = '{'{16'd3, 8'd1, 16'd1, 16'd0, 1'b1}, 1'b0, '0};
        ramp_rows[17] = '{'{16'd1000, 8'd1, 16'd1700, 16'd1699, 1'b1}, 1'b0, '0};
        ramp_rows[18] = '{'{16'd2, 8'd0, 16'd9, 16'd9, 1'b0}, 1'b0, '0};
        ramp_rows[19] = '{'{16'd1, 8'd0, 16'd9, 16'd9, 1'b1}, 1'b0, '0};
        ramp_rows[20] = '{'{16'd65535, 8'd0, 16'd65535, 16'd65535, 1'b1}, 1'b0, '0};
    end

    // Sender, end of run and final verdict.
    initial begin
        ramp_item_t   cur;
        duty_result_t due;
        int           accepted;
        int           offered;
        int           cur_row;
        aresetn             = 1'b0;
        s_valid             = 1'b0;
        s_request_speed     = '0;
        s_direction_request = '0;
        s_wheel_a_speed     = '0;
        s_wheel_b_speed     = '0;
        s_measurement_new   = 1'b0;
        held_duty_model     = '0;
        held_reverse_model  = 1'b0;
        calm                = 1'b0;
        fail_count          = 0;
        accepted            = 0;
        offered             = 0;
        cur_row             = 0;
        cur                 = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        while (accepted < TotalItems) begin
            @(posedge aclk);
            if (s_valid && s_ready) begin
                due = predict_ramp_update(cur);
                if (cur_row < NumRows && ramp_rows[cur_row].typed) begin
                    due = ramp_rows[cur_row].res;
                end
                due_duty_q.push_back(due);
                accepted++;
                calm <= (accepted >= 900 && accepted < 1100);
            end
            if (!s_valid || s_ready) begin
                if (offered < TotalItems && (calm || $urandom_range(99) >= 32)) begin
                    cur     = (offered < NumRows) ? ramp_rows[offered].item : random_ramp_item();
                    cur_row = offered;
                    offered++;
                    s_request_speed     <= cur.req;
                    s_direction_request <= cur.dir;
                    s_wheel_a_speed     <= cur.left;
                    s_wheel_b_speed     <= cur.right;
                    s_measurement_new   <= cur.fresh;
                    s_valid             <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
        while (due_duty_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Receiver: random stalls, and one long hold-off that fills the block.
    initial begin
        bit held_off;
        held_off = 1'b0;
        m_ready  = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!held_off && results_seen >= 400) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HoldOff) @(posedge aclk);
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 32);
            end
        end
    end

    initial results_seen = 0;

    always @(posedge aclk) begin
        duty_result_t due;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (due_duty_q.size() == 0) begin
                $display("%0t: unexpected result item, duty %0d reverse %0d",
                         $time, m_duty, m_reverse);
                fail_count++;
            end else begin
                due = due_duty_q.pop_front();
                if (m_duty !== due.duty) begin
                    $display("%0t: duty expected %0d actual %0d", $time, due.duty, m_duty);
                    fail_count++;
                end
                if (m_reverse !== due.reverse) begin
                    $display("%0t: reverse expected %0d actual %0d",
                             $time, due.reverse, m_reverse);
                    fail_count++;
                end
            end
        end
    end

    initial quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("%0t: no item moved for %0d cycles", $time, QuietLimit);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
